/* sv/ectok_pkg.sv */
// ectok_pkg: shared types, constants and character class helpers
// for the expression character tokenizer
// no dependencies
package ectok_pkg;

	// offset and count width inside the lexer
	localparam int POS_BITS = 16;

	// up to three tokens come out of one character beat
	localparam int MAX_TOK = 3;
	localparam int FIFO_DEPTH = 4;

	typedef logic [POS_BITS-1:0] pos_t;

	// token kinds
	localparam logic [1:0] KIND_OP  = 2'd0;
	localparam logic [1:0] KIND_NUM = 2'd1;
	localparam logic [1:0] KIND_END = 2'd2;
	localparam logic [1:0] KIND_ERR = 2'd3;

	// characters with a meaning of their own
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_SPACE = 8'h20;

	// largest value that can take one more decimal digit
	localparam logic [63:0] ACC_LIM = 64'h1999_9999_9999_9999;

	// one input beat
	typedef struct packed {
		logic [7:0] char_code;
		logic       char_valid;
		logic       end_of_text;
	} item_t;

	// one token
	typedef struct packed {
		logic [1:0]         token_kind;
		logic signed [31:0] number_value;
		logic [7:0]         op_first;
		logic [7:0]         op_second;
		logic [15:0]        start_pos;
		logic [15:0]        token_len;
		logic               last_token;
	} tok_t;

	// tokens produced by one beat, slot 0 first
	typedef struct packed {
		logic [1:0]           cnt;
		tok_t [MAX_TOK-1:0]   tok;
	} lex_out_t;

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SPACE) || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic is_punct(input logic [7:0] c);
		return (c >= 8'h21 && c <= 8'h2F) || (c >= 8'h3A && c <= 8'h40) ||
			(c >= 8'h5B && c <= 8'h60) || (c >= 8'h7B && c <= 8'h7E);
	endfunction

	function automatic logic starts_pair(input logic [7:0] c);
		return (c == CH_EQ) || (c == CH_BANG) || (c == CH_LT) || (c == CH_GT);
	endfunction

	// saturating increment of an offset or count
	function automatic pos_t pos_inc(input pos_t v);
		return (v == '1) ? v : pos_t'(v + pos_t'(1));
	endfunction

	// offset or count clamped to the 16-bit token field
	function automatic logic [15:0] to16(input pos_t v);
		logic [31:0] w;
		w = 32'(v);
		return (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
	endfunction

endpackage

/* sv/ectok_lexer.sv */
// ectok_lexer: lexer state and per-character token decisions
// works on the registered input beat, produces up to three tokens per beat
// depends on ectok_pkg
module ectok_lexer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              go,
	input  ectok_pkg::item_t  item,
	output ectok_pkg::lex_out_t lex_out
);

	localparam logic [1:0] MODE_IDLE    = 2'd0;
	localparam logic [1:0] MODE_NUMBER  = 2'd1;
	localparam logic [1:0] MODE_PENDING = 2'd2;
	localparam logic [1:0] MODE_DISCARD = 2'd3;

	logic [1:0]        mode_q;
	logic [63:0]       accum_q;
	logic [7:0]        pend_q;
	ectok_pkg::pos_t   start_q;
	ectok_pkg::pos_t   pos_q;
	ectok_pkg::pos_t   dcount_q;

	logic [1:0]        mode_d;
	logic [63:0]       accum_d;
	logic [7:0]        pend_d;
	ectok_pkg::pos_t   start_d;
	ectok_pkg::pos_t   pos_d;
	ectok_pkg::pos_t   dcount_d;

	function automatic ectok_pkg::tok_t mk_tok(
		input logic [1:0]      kind,
		input logic [31:0]     value,
		input logic [7:0]      op1,
		input logic [7:0]      op2,
		input ectok_pkg::pos_t start,
		input ectok_pkg::pos_t len,
		input logic            last
	);
		ectok_pkg::tok_t t;
		t.token_kind   = kind;
		t.number_value = signed'(value);
		t.op_first     = op1;
		t.op_second    = op2;
		t.start_pos    = ectok_pkg::to16(start);
		t.token_len    = ectok_pkg::to16(len);
		t.last_token   = last;
		return t;
	endfunction

	// token decisions for the current beat
	always_comb begin
		logic [7:0]  c;
		logic        consumed;
		logic        done;
		logic [63:0] d;
		logic [1:0]  n;
		c        = item.char_code;
		consumed = 1'b0;
		done     = 1'b0;
		d        = 64'(c - ectok_pkg::CH_ZERO);
		n        = 2'd0;
		mode_d   = mode_q;
		accum_d  = accum_q;
		pend_d   = pend_q;
		start_d  = start_q;
		pos_d    = pos_q;
		dcount_d = dcount_q;
		lex_out  = '0;

		if (mode_q == MODE_DISCARD) begin
			// swallow everything up to the end of the text
			if (item.end_of_text) begin
				mode_d   = MODE_IDLE;
				accum_d  = '0;
				pend_d   = '0;
				start_d  = '0;
				pos_d    = '0;
				dcount_d = '0;
			end
		end else begin
			if (item.char_valid) begin
				// a number ends at the first non-digit
				if (mode_d == MODE_NUMBER && !ectok_pkg::is_digit(c)) begin
					lex_out.tok[n] = mk_tok(ectok_pkg::KIND_NUM, accum_d[31:0], 8'd0, 8'd0,
						start_d, dcount_d, 1'b0);
					n = n + 2'd1;
					mode_d = MODE_IDLE;
				end
				// pending operator either pairs with '=' or goes out alone
				if (mode_d == MODE_PENDING) begin
					if (c == ectok_pkg::CH_EQ) begin
						lex_out.tok[n] = mk_tok(ectok_pkg::KIND_OP, 32'd0, pend_d, c,
							start_d, ectok_pkg::pos_t'(2), 1'b0);
						consumed = 1'b1;
					end else begin
						lex_out.tok[n] = mk_tok(ectok_pkg::KIND_OP, 32'd0, pend_d, 8'd0,
							start_d, ectok_pkg::pos_t'(1), 1'b0);
					end
					n = n + 2'd1;
					mode_d = MODE_IDLE;
				end
				// lex the character afresh
				if (!consumed) begin
					if (ectok_pkg::is_space(c)) begin
						mode_d = mode_d;
					end else if (ectok_pkg::is_digit(c)) begin
						if (mode_d == MODE_NUMBER) begin
							if (accum_d > ectok_pkg::ACC_LIM ||
								(accum_d == ectok_pkg::ACC_LIM && d > 64'd5)) begin
								accum_d = '1;
							end else begin
								accum_d = (accum_d << 3) + (accum_d << 1) + d;
							end
							dcount_d = ectok_pkg::pos_inc(dcount_d);
						end else begin
							mode_d   = MODE_NUMBER;
							accum_d  = d;
							start_d  = pos_d;
							dcount_d = ectok_pkg::pos_t'(1);
						end
					end else if (ectok_pkg::starts_pair(c)) begin
						mode_d  = MODE_PENDING;
						pend_d  = c;
						start_d = pos_d;
					end else if (ectok_pkg::is_punct(c)) begin
						lex_out.tok[n] = mk_tok(ectok_pkg::KIND_OP, 32'd0, c, 8'd0,
							pos_d, ectok_pkg::pos_t'(1), 1'b0);
						n = n + 2'd1;
					end else begin
						// invalid character closes the text
						lex_out.tok[n] = mk_tok(ectok_pkg::KIND_ERR, 32'd0, c, 8'd0,
							pos_d, ectok_pkg::pos_t'(1), 1'b1);
						n = n + 2'd1;
						done = 1'b1;
						if (item.end_of_text) begin
							mode_d   = MODE_IDLE;
							accum_d  = '0;
							pend_d   = '0;
							start_d  = '0;
							pos_d    = '0;
							dcount_d = '0;
						end else begin
							mode_d = MODE_DISCARD;
							pos_d  = ectok_pkg::pos_inc(pos_d);
						end
					end
				end
				if (!done) begin
					pos_d = ectok_pkg::pos_inc(pos_d);
				end
			end
			// end of text: flush, end token, fresh state
			if (item.end_of_text && !done) begin
				if (mode_d == MODE_NUMBER) begin
					lex_out.tok[n] = mk_tok(ectok_pkg::KIND_NUM, accum_d[31:0], 8'd0, 8'd0,
						start_d, dcount_d, 1'b0);
					n = n + 2'd1;
				end else if (mode_d == MODE_PENDING) begin
					lex_out.tok[n] = mk_tok(ectok_pkg::KIND_OP, 32'd0, pend_d, 8'd0,
						start_d, ectok_pkg::pos_t'(1), 1'b0);
					n = n + 2'd1;
				end
				lex_out.tok[n] = mk_tok(ectok_pkg::KIND_END, 32'd0, 8'd0, 8'd0,
					pos_d, ectok_pkg::pos_t'(0), 1'b1);
				n = n + 2'd1;
				mode_d   = MODE_IDLE;
				accum_d  = '0;
				pend_d   = '0;
				start_d  = '0;
				pos_d    = '0;
				dcount_d = '0;
			end
		end
		lex_out.cnt = n;
	end

	// lexer state, updated when a beat is processed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE;
			accum_q  <= '0;
			pend_q   <= '0;
			start_q  <= '0;
			pos_q    <= '0;
			dcount_q <= '0;
		end else if (go) begin
			mode_q   <= mode_d;
			accum_q  <= accum_d;
			pend_q   <= pend_d;
			start_q  <= start_d;
			pos_q    <= pos_d;
			dcount_q <= dcount_d;
		end
	end

	// end of text always leaves a fresh lexer
	a_eot_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(go && item.end_of_text) |=> (mode_q == MODE_IDLE && pos_q == '0))
		else $error("lexer state not cleared at end of text");

	// nothing comes out while discarding
	a_discard_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_DISCARD) |-> (lex_out.cnt == 2'd0))
		else $error("token produced while discarding");

	// a beat whose last token closes the text leaves the lexer idle or discarding
	a_last_is_final: assert property (@(posedge clk) disable iff (!arst_n)
		(go && lex_out.cnt != 2'd0 && lex_out.tok[lex_out.cnt - 2'd1].last_token)
		|=> (mode_q == MODE_IDLE || mode_q == MODE_DISCARD))
		else $error("closing token left the lexer mid token");

endmodule

/* sv/ectok_fifo.sv */
// ectok_fifo: token queue that takes up to three tokens a beat
// and hands out one token per beat
// depends on ectok_pkg
module ectok_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  ectok_pkg::lex_out_t wr,
	input  logic                pop,
	output logic                not_empty,
	output logic                room,
	output ectok_pkg::tok_t     head
);

	localparam int PTR_W = $clog2(ectok_pkg::FIFO_DEPTH);
	localparam int CNT_W = $clog2(ectok_pkg::FIFO_DEPTH + 1);

	ectok_pkg::tok_t   mem_q [ectok_pkg::FIFO_DEPTH];
	logic [PTR_W-1:0]  rd_q;
	logic [PTR_W-1:0]  wr_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  n_push;

	assign n_push    = push ? CNT_W'(wr.cnt) : '0;
	assign not_empty = (cnt_q != '0);
	assign head      = mem_q[rd_q];
	// space for a full beat of tokens
	assign room      = (cnt_q <= CNT_W'(ectok_pkg::FIFO_DEPTH - ectok_pkg::MAX_TOK));

	// token storage
	always_ff @(posedge clk) begin
		for (int i = 0; i < ectok_pkg::MAX_TOK; i++) begin
			if (push && CNT_W'(i) < CNT_W'(wr.cnt)) begin
				mem_q[PTR_W'(wr_q + PTR_W'(i))] <= wr.tok[i];
			end
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= '0;
			wr_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= PTR_W'(wr_q + PTR_W'(n_push));
			if (pop) begin
				rd_q <= PTR_W'(rd_q + PTR_W'(1));
			end
			cnt_q <= CNT_W'(cnt_q + n_push - CNT_W'(pop));
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(n_push != '0) |-> (cnt_q <= CNT_W'(ectok_pkg::FIFO_DEPTH) - n_push))
		else $error("token queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("token queue underflow");

endmodule

/* sv/expression_char_tokenizer_unit.sv */
// expression_char_tokenizer_unit: streaming lexer for expression text, one character a beat
// path: an accepted beat is held in the input register and lexed from there; its tokens are written
// into the queue, whose head drives the token outputs until the token is taken
// throughput: one character beat per cycle while each beat gives at most one token and token_stall is low;
// tokens leave one per cycle while token_stall is low, through a four-entry queue, which sets the rate on busy beats
// reset: arst_n clears the input valid flag, lexer state and queue pointers at once; no clearing pass
// depends on ectok_pkg, ectok_lexer, ectok_fifo
module expression_char_tokenizer_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic [7:0]         char_code,
	input  logic               char_valid,
	input  logic               end_of_text,
	output logic               token_valid,
	input  logic               token_stall,
	output logic [1:0]         token_kind,
	output logic signed [31:0] number_value,
	output logic [7:0]         op_first,
	output logic [7:0]         op_second,
	output logic [15:0]        start_pos,
	output logic [15:0]        token_len,
	output logic               last_token
);

	ectok_pkg::item_t    item_s1;
	logic                valid_s1;
	logic                go;
	logic                room;
	logic                pop;
	ectok_pkg::lex_out_t lex_out;
	ectok_pkg::tok_t     head;

	// beat is processed once the queue has room for a full beat of tokens
	assign go         = valid_s1 && room;
	assign item_stall = valid_s1 && !room;
	assign pop        = token_valid && !token_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1.char_code   <= char_code;
			item_s1.char_valid  <= char_valid;
			item_s1.end_of_text <= end_of_text;
		end
	end

	ectok_lexer u_lexer (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (go),
		.item    (item_s1),
		.lex_out (lex_out)
	);

	ectok_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (go),
		.wr        (lex_out),
		.pop       (pop),
		.not_empty (token_valid),
		.room      (room),
		.head      (head)
	);

	// token fields
	assign token_kind   = head.token_kind;
	assign number_value = head.number_value;
	assign op_first     = head.op_first;
	assign op_second    = head.op_second;
	assign start_pos    = head.start_pos;
	assign token_len    = head.token_len;
	assign last_token   = head.last_token;

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// tb: self-checking bench for expression_char_tokenizer_unit, character beats in, tokens out
// holds a token ledger class that predicts tokens from accepted beats and matches them
// depends on ectok_pkg and expression_char_tokenizer_unit
module tb;

	// lexer modes of the predictor
	typedef enum logic [1:0] {LX_IDLE, LX_NUMBER, LX_PENDING, LX_DISCARD} lex_mode_e;

	// largest accumulator value that still takes another decimal digit
	localparam logic [63:0] TEN_LIMIT = 64'hFFFF_FFFF_FFFF_FFFF / 10;

	// predicts tokens from accepted character beats and matches them in order
	class token_ledger;
		lex_mode_e         mode;
		logic [63:0]       accum;
		logic [7:0]        held_op;
		ectok_pkg::pos_t   tok_start;
		ectok_pkg::pos_t   next_pos;
		ectok_pkg::pos_t   ndigits;
		ectok_pkg::tok_t   due_tokens[$];
		int                errors;

		function new();
			errors = 0;
			restart();
		endfunction

		function void restart();
			mode      = LX_IDLE;
			accum     = '0;
			held_op   = '0;
			tok_start = '0;
			next_pos  = '0;
			ndigits   = '0;
		endfunction

		function ectok_pkg::pos_t bump(ectok_pkg::pos_t v);
			return (v == {$bits(ectok_pkg::pos_t){1'b1}}) ? v :
				ectok_pkg::pos_t'(v + 1'b1);
		endfunction

		function logic [15:0] clamp16(ectok_pkg::pos_t v);
			if ($bits(ectok_pkg::pos_t) > 16 && v > ectok_pkg::pos_t'(16'hFFFF))
				return 16'hFFFF;
			return 16'(v);
		endfunction

		function logic is_dec(logic [7:0] c);
			return c >= ectok_pkg::CH_ZERO && c <= ectok_pkg::CH_NINE;
		endfunction

		function logic is_blank(logic [7:0] c);
			return c == ectok_pkg::CH_SPACE || (c >= 8'h09 && c <= 8'h0D);
		endfunction

		// printable, not blank, not a digit and not a letter
		function logic is_sign(logic [7:0] c);
			logic [7:0] lc;
			lc = c | 8'h20;
			return c > ectok_pkg::CH_SPACE && c < 8'h7F && !is_dec(c) &&
				!(lc >= 8'h61 && lc <= 8'h7A);
		endfunction

		function logic opens_pair(logic [7:0] c);
			return c == ectok_pkg::CH_EQ || c == ectok_pkg::CH_BANG ||
				c == ectok_pkg::CH_LT || c == ectok_pkg::CH_GT;
		endfunction

		function void push_tok(logic [1:0] kind, logic [31:0] value, logic [7:0] c1,
				logic [7:0] c2, ectok_pkg::pos_t start, ectok_pkg::pos_t len, logic last);
			ectok_pkg::tok_t t;
			t.token_kind   = kind;
			t.number_value = value;
			t.op_first     = c1;
			t.op_second    = c2;
			t.start_pos    = clamp16(start);
			t.token_len    = clamp16(len);
			t.last_token   = last;
			due_tokens.push_back(t);
		endfunction

		// close a number or a single operator still in progress
		function void close_run();
			if (mode == LX_NUMBER)
				push_tok(ectok_pkg::KIND_NUM, accum[31:0], 8'h00, 8'h00, tok_start,
					ndigits, 1'b0);
			else if (mode == LX_PENDING)
				push_tok(ectok_pkg::KIND_OP, 32'd0, held_op, 8'h00, tok_start,
					ectok_pkg::pos_t'(1), 1'b0);
			mode = LX_IDLE;
		endfunction

		function void take_char(logic [7:0] c, logic v, logic e);
			logic        used;
			logic [63:0] d;
			used = 1'b0;
			d = {56'd0, c - ectok_pkg::CH_ZERO};
			// after an error everything up to the end of the text is dropped
			if (mode == LX_DISCARD) begin
				if (e)
					restart();
				return;
			end
			if (v) begin
				if (mode == LX_NUMBER && !is_dec(c))
					close_run();
				if (mode == LX_PENDING) begin
					if (c == ectok_pkg::CH_EQ) begin
						push_tok(ectok_pkg::KIND_OP, 32'd0, held_op, c, tok_start,
							ectok_pkg::pos_t'(2), 1'b0);
						mode = LX_IDLE;
						used = 1'b1;
					end else begin
						close_run();
					end
				end
				if (!used) begin
					if (is_dec(c)) begin
						if (mode == LX_NUMBER) begin
							if (accum > TEN_LIMIT || (accum == TEN_LIMIT && d > 64'd5))
								accum = '1;
							else
								accum = accum * 10 + d;
							ndigits = bump(ndigits);
						end else begin
							mode      = LX_NUMBER;
							accum     = d;
							tok_start = next_pos;
							ndigits   = ectok_pkg::pos_t'(1);
						end
					end else if (opens_pair(c)) begin
						mode      = LX_PENDING;
						held_op   = c;
						tok_start = next_pos;
					end else if (is_sign(c)) begin
						push_tok(ectok_pkg::KIND_OP, 32'd0, c, 8'h00, next_pos,
							ectok_pkg::pos_t'(1), 1'b0);
					end else if (!is_blank(c)) begin
						push_tok(ectok_pkg::KIND_ERR, 32'd0, c, 8'h00, next_pos,
							ectok_pkg::pos_t'(1), 1'b1);
						if (e) begin
							restart();
						end else begin
							mode     = LX_DISCARD;
							next_pos = bump(next_pos);
						end
						return;
					end
				end
				next_pos = bump(next_pos);
			end
			if (e) begin
				close_run();
				push_tok(ectok_pkg::KIND_END, 32'd0, 8'h00, 8'h00, next_pos,
					ectok_pkg::pos_t'(0), 1'b1);
				restart();
			end
		endfunction

		function void diff(string name, logic [63:0] want, logic [63:0] got);
			if (want !== got) begin
				$error("%s: expected %0h, got %0h", name, want, got);
				errors++;
			end
		endfunction

		function void match_token(ectok_pkg::tok_t got);
			ectok_pkg::tok_t want;
			if (due_tokens.size() == 0) begin
				$error("token with nothing due: kind %0d at %0d", got.token_kind, got.start_pos);
				errors++;
				return;
			end
			want = due_tokens.pop_front();
			diff("token_kind", want.token_kind, got.token_kind);
			diff("number_value", want.number_value, got.number_value);
			diff("op_first", want.op_first, got.op_first);
			diff("op_second", want.op_second, got.op_second);
			diff("start_pos", want.start_pos, got.start_pos);
			diff("token_len", want.token_len, got.token_len);
			diff("last_token", want.last_token, got.last_token);
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n;
	logic               item_valid;
	logic               item_stall;
	logic [7:0]         char_code;
	logic               char_valid;
	logic               end_of_text;
	logic               token_valid;
	logic               token_stall = 1'b0;
	logic [1:0]         token_kind;
	logic signed [31:0] number_value;
	logic [7:0]         op_first;
	logic [7:0]         op_second;
	logic [15:0]        start_pos;
	logic [15:0]        token_len;
	logic               last_token;

	token_ledger ledger;
	int          gap_pct = 0;
	int          stall_pct = 0;
	int          beats_sent = 0;

	expression_char_tokenizer_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.char_code    (char_code),
		.char_valid   (char_valid),
		.end_of_text  (end_of_text),
		.token_valid  (token_valid),
		.token_stall  (token_stall),
		.token_kind   (token_kind),
		.number_value (number_value),
		.op_first     (op_first),
		.op_second    (op_second),
		.start_pos    (start_pos),
		.token_len    (token_len),
		.last_token   (last_token)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// receiver back-pressure
	always @(negedge clk) begin
		token_stall <= ($urandom_range(99) < stall_pct);
	end

	// token monitor
	always @(posedge clk) begin
		ectok_pkg::tok_t seen;
		seen = {token_kind, number_value, op_first, op_second, start_pos, token_len, last_token};
		if (arst_n && token_valid && !token_stall)
			ledger.match_token(seen);
	end

	// one character beat, with random idle cycles in front of it
	task automatic send_beat(input logic [7:0] c, input logic v, input logic e);
		while ($urandom_range(99) < gap_pct) begin
			item_valid <= 1'b0;
			char_code  <= 8'($urandom);
			@(negedge clk);
		end
		item_valid  <= 1'b1;
		char_code   <= c;
		char_valid  <= v;
		end_of_text <= e;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		ledger.take_char(c, v, e);
		beats_sent++;
		@(negedge clk);
	endtask

	task automatic send_text(input string s, input logic close);
		for (int i = 0; i < s.len(); i++)
			send_beat(s[i], 1'b1, close && i == s.len() - 1);
	endtask

	function automatic logic [7:0] any_sign();
		logic [7:0] c;
		c = 8'($urandom_range(8'h21, 8'h7E));
		while (!ledger.is_sign(c))
			c = 8'($urandom_range(8'h21, 8'h7E));
		return c;
	endfunction

	function automatic logic [7:0] any_pair_opener();
		case ($urandom_range(3))
			0: return ectok_pkg::CH_EQ;
			1: return ectok_pkg::CH_BANG;
			2: return ectok_pkg::CH_LT;
			default: return ectok_pkg::CH_GT;
		endcase
	endfunction

	function automatic logic [7:0] any_blank();
		int k;
		k = $urandom_range(8, 13);
		return (k == 8) ? ectok_pkg::CH_SPACE : 8'(k);
	endfunction

	function automatic logic [7:0] any_digit();
		return ectok_pkg::CH_ZERO + 8'($urandom_range(9));
	endfunction

	// mostly well-formed text with random content; some texts carry stray bytes
	task automatic send_random_text();
		int         pieces;
		int         n;
		logic       noisy;
		logic [7:0] c;
		pieces = $urandom_range(1, 10);
		noisy  = ($urandom_range(3) == 0);
		for (int i = 0; i < pieces; i++) begin
			if (noisy && $urandom_range(5) == 0)
				send_beat(8'($urandom), 1'b1, 1'b0);
			case ($urandom_range(9))
				0, 1, 2: begin
					n = ($urandom_range(7) == 0) ? $urandom_range(18, 24) : $urandom_range(1, 4);
					repeat (n)
						send_beat(any_digit(), 1'b1, 1'b0);
				end
				3, 4: begin
					send_beat(any_pair_opener(), 1'b1, 1'b0);
					if ($urandom_range(1))
						send_beat(ectok_pkg::CH_EQ, 1'b1, 1'b0);
				end
				5, 6: send_beat(any_sign(), 1'b1, 1'b0);
				7: repeat ($urandom_range(1, 2)) send_beat(any_blank(), 1'b1, 1'b0);
				8: send_beat(8'($urandom), 1'b0, 1'b0);
				default: send_beat(($urandom_range(1)) ? any_pair_opener() : any_sign(),
						1'b1, 1'b0);
			endcase
		end
		// close the text on a last character or on a bare end beat
		if ($urandom_range(4) == 0) begin
			send_beat(8'($urandom), 1'b0, 1'b1);
		end else begin
			case ($urandom_range(9))
				0, 1, 2: c = any_digit();
				3, 4: c = any_sign();
				5, 6: c = ectok_pkg::CH_EQ;
				7: c = any_blank();
				8: c = any_pair_opener();
				default: c = 8'($urandom);
			endcase
			send_beat(c, 1'b1, 1'b1);
		end
	endtask

	// run limit
	initial begin
		#15_000_000;
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		int start;
		ledger      = new();
		arst_n      = 1'b0;
		item_valid  = 1'b0;
		char_code   = 8'h00;
		char_valid  = 1'b0;
		end_of_text = 1'b0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed texts
		send_text("<=!", 1'b0);
		send_beat(8'h00, 1'b0, 1'b1);       // pending operator closed by a bare end
		send_text(">a79", 1'b1);            // error after a pending operator, then discard
		send_text("9\t\r==", 1'b1);         // blanks, a pair, end on the same beat
		send_beat(8'hFF, 1'b0, 1'b0);       // empty beat, no effect
		send_text("~", 1'b1);
		send_beat(8'h80, 1'b1, 1'b1);       // error on the end beat
		send_beat(8'h00, 1'b1, 1'b1);
		send_beat(8'hFF, 1'b1, 1'b1);
		send_text("42,<5 ", 1'b1);          // pending then non-matching digit
		send_beat(8'h00, 1'b0, 1'b1);       // bare end with nothing open

		// random texts under each idling pattern
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin gap_pct = 0;  stall_pct = 0;  end
				1: begin gap_pct = 55; stall_pct = 0;  end
				2: begin gap_pct = 0;  stall_pct = 55; end
				default: begin gap_pct = 20; stall_pct = 20; end
			endcase
			start = beats_sent;
			while (beats_sent - start < 80)
				send_random_text();
		end
		item_valid <= 1'b0;
		stall_pct = 0;

		// drain, then watch for stray tokens
		while (ledger.due_tokens.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (ledger.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
